// File: sv/dlle_pkg.sv
// ----------------------------------------------------------------------------
// dlle_pkg
// Shared types and constants for the doubly linked list engine: store
// geometry, command and status codes, and the request and response bundles
// between the sequencer and the link store.
// ----------------------------------------------------------------------------
package dlle_pkg;

    localparam int NODES  = 1024;
    localparam int IDX_W  = $clog2(NODES);
    localparam int SLOT_W = $clog2(NODES + 2);
    localparam int REF_W  = 11;
    localparam int CMD_W  = 3;
    localparam int STS_W  = 2;
    localparam int DATA_W = 32;

    localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] TAIL_SLOT = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NODES + 1);
    localparam logic [REF_W-1:0]  FULL_REFS = REF_W'(NODES);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT    = 3'd0,
        CMD_PUSH_BACK     = 3'd1,
        CMD_INSERT_BEFORE = 3'd2,
        CMD_INSERT_AFTER  = 3'd3,
        CMD_DELETE        = 3'd4,
        CMD_QUERY_NEXT    = 3'd5
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_OK   = 2'd0,
        STS_FULL = 2'd1,
        STS_BAD  = 2'd2
    } t_status;

    // Link ports take slot numbers; the store maps the sentinels itself.
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
        logic              vrd_en;
        logic [IDX_W-1:0]  vrd_idx;
        logic              nx_we;
        logic [SLOT_W-1:0] nx_slot;
        logic [SLOT_W-1:0] nx_data;
        logic              pv_we;
        logic [SLOT_W-1:0] pv_slot;
        logic [SLOT_W-1:0] pv_data;
        logic              dd_we;
        logic [IDX_W-1:0]  dd_idx;
        logic              dd_data;
        logic              vl_we;
        logic [IDX_W-1:0]  vl_idx;
        logic [DATA_W-1:0] vl_data;
    } t_store_req;

    typedef struct packed {
        logic [SLOT_W-1:0] next_q;
        logic [SLOT_W-1:0] prev_q;
        logic              dead_q;
        logic [DATA_W-1:0] val_q;
        logic [SLOT_W-1:0] head_next;
        logic [SLOT_W-1:0] tail_prev;
    } t_store_rsp;

endpackage

// File: sv/doubly_linked_list_engine_top.sv
// Results are registered in S_EVAL for errors and end-of-list queries, in S_UNLINK
// for delete, in S_QDONE for a query, and in S_NBR after S_NEW for push and insert.
// A new command is taken only in S_IDLE, so one is in flight at a time; each link
// memory has a single write port: an insert writes the new node, then both neighbors.
// Reset: synchronous, active low; the list is empty at once, with no clearing pass.
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_top
// Array-based doubly linked list with head and tail sentinels, one result
// per command.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [dlle_pkg::CMD_W-1:0]         i_command,
    input  logic [dlle_pkg::REF_W-1:0]         i_node_ref,
    input  logic signed [dlle_pkg::DATA_W-1:0] i_data_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [dlle_pkg::STS_W-1:0]         o_status,
    output logic [dlle_pkg::REF_W-1:0]         o_assigned_ref,
    output logic [dlle_pkg::REF_W-1:0]         o_successor_ref,
    output logic signed [dlle_pkg::DATA_W-1:0] o_successor_value,
    output logic                               o_at_end
);

    dlle_pkg::t_store_req store_req;
    dlle_pkg::t_store_rsp store_rsp;

    dlle_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_node_ref        (i_node_ref),
        .i_data_value      (i_data_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_assigned_ref    (o_assigned_ref),
        .o_successor_ref   (o_successor_ref),
        .o_successor_value (o_successor_value),
        .o_at_end          (o_at_end),
        .o_req             (store_req),
        .i_rsp             (store_rsp)
    );

    dlle_link_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rsp   (store_rsp)
    );

endmodule

// File: sv/dlle_link_store.sv
// ----------------------------------------------------------------------------
// dlle_link_store
// Node value, link and deleted-flag memories plus the two sentinel link
// registers. Reads are registered; one write per memory per cycle.
// ----------------------------------------------------------------------------
module dlle_link_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dlle_pkg::t_store_req i_req,
    output dlle_pkg::t_store_rsp o_rsp
);

    logic [dlle_pkg::SLOT_W-1:0] next_mem [dlle_pkg::NODES];
    logic [dlle_pkg::SLOT_W-1:0] prev_mem [dlle_pkg::NODES];
    logic                        dead_mem [dlle_pkg::NODES];
    logic [dlle_pkg::DATA_W-1:0] val_mem  [dlle_pkg::NODES];

    logic [dlle_pkg::SLOT_W-1:0] r_head_next;
    logic [dlle_pkg::SLOT_W-1:0] r_tail_prev;
    logic [dlle_pkg::SLOT_W-1:0] r_next_q;
    logic [dlle_pkg::SLOT_W-1:0] r_prev_q;
    logic                        r_dead_q;
    logic [dlle_pkg::DATA_W-1:0] r_val_q;

    logic [dlle_pkg::IDX_W-1:0]  nx_idx;
    logic [dlle_pkg::IDX_W-1:0]  pv_idx;

    // Node slots start right after the two sentinels.
    assign nx_idx = dlle_pkg::IDX_W'(i_req.nx_slot - dlle_pkg::SLOT_W'(2));
    assign pv_idx = dlle_pkg::IDX_W'(i_req.pv_slot - dlle_pkg::SLOT_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_next <= dlle_pkg::TAIL_SLOT;
            r_tail_prev <= dlle_pkg::HEAD_SLOT;
        end else begin
            if (i_req.nx_we && i_req.nx_slot == dlle_pkg::HEAD_SLOT) begin
                r_head_next <= i_req.nx_data;
            end
            if (i_req.pv_we && i_req.pv_slot == dlle_pkg::TAIL_SLOT) begin
                r_tail_prev <= i_req.pv_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.nx_we && i_req.nx_slot != dlle_pkg::HEAD_SLOT) begin
            next_mem[nx_idx] <= i_req.nx_data;
        end
        if (i_req.pv_we && i_req.pv_slot != dlle_pkg::TAIL_SLOT) begin
            prev_mem[pv_idx] <= i_req.pv_data;
        end
        if (i_req.dd_we) begin
            dead_mem[i_req.dd_idx] <= i_req.dd_data;
        end
        if (i_req.vl_we) begin
            val_mem[i_req.vl_idx] <= i_req.vl_data;
        end
        if (i_req.rd_en) begin
            r_next_q <= next_mem[i_req.rd_idx];
            r_prev_q <= prev_mem[i_req.rd_idx];
            r_dead_q <= dead_mem[i_req.rd_idx];
        end
        if (i_req.vrd_en) begin
            r_val_q <= val_mem[i_req.vrd_idx];
        end
    end

    assign o_rsp.next_q    = r_next_q;
    assign o_rsp.prev_q    = r_prev_q;
    assign o_rsp.dead_q    = r_dead_q;
    assign o_rsp.val_q     = r_val_q;
    assign o_rsp.head_next = r_head_next;
    assign o_rsp.tail_prev = r_tail_prev;

endmodule

// File: sv/dlle_seq.sv
// ----------------------------------------------------------------------------
// dlle_seq
// Command sequencer: checks the reference, chooses the neighbor slots, steps
// the link store through its writes and holds the result register.
// ----------------------------------------------------------------------------
module dlle_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [dlle_pkg::CMD_W-1:0]         i_command,
    input  logic [dlle_pkg::REF_W-1:0]         i_node_ref,
    input  logic signed [dlle_pkg::DATA_W-1:0] i_data_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [dlle_pkg::STS_W-1:0]         o_status,
    output logic [dlle_pkg::REF_W-1:0]         o_assigned_ref,
    output logic [dlle_pkg::REF_W-1:0]         o_successor_ref,
    output logic signed [dlle_pkg::DATA_W-1:0] o_successor_value,
    output logic                               o_at_end,
    output dlle_pkg::t_store_req               o_req,
    input  dlle_pkg::t_store_rsp               i_rsp
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_NEW    = 6'b000100,
        S_NBR    = 6'b001000,
        S_UNLINK = 6'b010000,
        S_QDONE  = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [dlle_pkg::CMD_W-1:0]  r_cmd;
    logic [dlle_pkg::REF_W-1:0]  r_ref;
    logic [dlle_pkg::DATA_W-1:0] r_val;
    logic [dlle_pkg::REF_W-1:0]  r_used, n_used;
    logic [dlle_pkg::SLOT_W-1:0] r_a, n_a;
    logic [dlle_pkg::SLOT_W-1:0] r_b, n_b;
    logic [dlle_pkg::REF_W-1:0]  r_sref, n_sref;

    logic                        r_out_valid;
    logic [dlle_pkg::STS_W-1:0]  r_status;
    logic [dlle_pkg::REF_W-1:0]  r_assigned;
    logic [dlle_pkg::REF_W-1:0]  r_succ_ref;
    logic [dlle_pkg::DATA_W-1:0] r_succ_val;
    logic                        r_at_end;

    logic                        accept;
    logic                        out_free;
    logic                        live;
    logic                        full;
    logic [dlle_pkg::SLOT_W-1:0] slot_k;
    logic [dlle_pkg::SLOT_W-1:0] new_slot;
    logic [dlle_pkg::SLOT_W-1:0] q_slot;
    logic                        q_end;

    logic                        fin;
    logic [dlle_pkg::STS_W-1:0]  fin_status;
    logic [dlle_pkg::REF_W-1:0]  fin_assigned;
    logic [dlle_pkg::REF_W-1:0]  fin_sref;
    logic [dlle_pkg::DATA_W-1:0] fin_sval;
    logic                        fin_end;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // A reference is live when it was handed out and never deleted; the
    // deleted flag of every handed-out node has been written at creation.
    assign live     = (r_ref != '0) && (r_ref <= r_used) && !i_rsp.dead_q;
    assign full     = (r_used == dlle_pkg::FULL_REFS);
    assign slot_k   = dlle_pkg::SLOT_W'(r_ref + dlle_pkg::REF_W'(1));
    assign new_slot = dlle_pkg::SLOT_W'(r_used + dlle_pkg::REF_W'(2));
    assign q_slot   = (r_ref == '0) ? i_rsp.head_next : i_rsp.next_q;
    assign q_end    = (q_slot < dlle_pkg::SLOT_W'(2)) || (q_slot > dlle_pkg::LAST_SLOT);

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_a          = r_a;
        n_b          = r_b;
        n_sref       = r_sref;
        fin          = 1'b0;
        fin_status   = dlle_pkg::STS_OK;
        fin_assigned = '0;
        fin_sref     = '0;
        fin_sval     = '0;
        fin_end      = 1'b0;
        o_req        = '0;
        o_req.rd_idx = dlle_pkg::IDX_W'(i_node_ref - dlle_pkg::REF_W'(1));

        unique case (r_state)
            S_IDLE: begin
                o_req.rd_en = accept;
                if (accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                unique case (r_cmd)
                    dlle_pkg::CMD_PUSH_FRONT, dlle_pkg::CMD_PUSH_BACK: begin
                        if (full) begin
                            fin_status = dlle_pkg::STS_FULL;
                            fin        = out_free;
                        end else begin
                            n_state = S_NEW;
                            if (r_cmd == dlle_pkg::CMD_PUSH_FRONT) begin
                                n_a = dlle_pkg::HEAD_SLOT;
                                n_b = i_rsp.head_next;
                            end else begin
                                n_a = i_rsp.tail_prev;
                                n_b = dlle_pkg::TAIL_SLOT;
                            end
                        end
                    end
                    dlle_pkg::CMD_INSERT_BEFORE, dlle_pkg::CMD_INSERT_AFTER: begin
                        // The reference check takes precedence over full.
                        if (!live) begin
                            fin_status = dlle_pkg::STS_BAD;
                            fin        = out_free;
                        end else if (full) begin
                            fin_status = dlle_pkg::STS_FULL;
                            fin        = out_free;
                        end else begin
                            n_state = S_NEW;
                            if (r_cmd == dlle_pkg::CMD_INSERT_BEFORE) begin
                                n_a = i_rsp.prev_q;
                                n_b = slot_k;
                            end else begin
                                n_a = slot_k;
                                n_b = i_rsp.next_q;
                            end
                        end
                    end
                    dlle_pkg::CMD_DELETE: begin
                        if (!live) begin
                            fin_status = dlle_pkg::STS_BAD;
                            fin        = out_free;
                        end else begin
                            n_state = S_UNLINK;
                            n_a     = i_rsp.prev_q;
                            n_b     = i_rsp.next_q;
                        end
                    end
                    dlle_pkg::CMD_QUERY_NEXT: begin
                        if (r_ref != '0 && !live) begin
                            fin_status = dlle_pkg::STS_BAD;
                            fin        = out_free;
                        end else if (q_end) begin
                            fin_end = 1'b1;
                            fin     = out_free;
                        end else begin
                            o_req.vrd_en  = 1'b1;
                            o_req.vrd_idx = dlle_pkg::IDX_W'(q_slot - dlle_pkg::SLOT_W'(2));
                            n_sref        = dlle_pkg::REF_W'(q_slot - dlle_pkg::SLOT_W'(1));
                            n_state       = S_QDONE;
                        end
                    end
                    default: begin
                        fin_status = dlle_pkg::STS_BAD;
                        fin        = out_free;
                    end
                endcase
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            S_NEW: begin
                o_req.vl_we   = 1'b1;
                o_req.vl_idx  = r_used[dlle_pkg::IDX_W-1:0];
                o_req.vl_data = r_val;
                o_req.dd_we   = 1'b1;
                o_req.dd_idx  = r_used[dlle_pkg::IDX_W-1:0];
                o_req.dd_data = 1'b0;
                o_req.nx_we   = 1'b1;
                o_req.nx_slot = new_slot;
                o_req.nx_data = r_b;
                o_req.pv_we   = 1'b1;
                o_req.pv_slot = new_slot;
                o_req.pv_data = r_a;
                n_state       = S_NBR;
            end
            S_NBR: begin
                // These writes repeat unchanged while the result waits.
                o_req.nx_we   = 1'b1;
                o_req.nx_slot = r_a;
                o_req.nx_data = new_slot;
                o_req.pv_we   = 1'b1;
                o_req.pv_slot = r_b;
                o_req.pv_data = new_slot;
                fin_assigned  = dlle_pkg::REF_W'(r_used + dlle_pkg::REF_W'(1));
                fin           = out_free;
                if (fin) begin
                    n_used  = fin_assigned;
                    n_state = S_IDLE;
                end
            end
            S_UNLINK: begin
                o_req.nx_we   = 1'b1;
                o_req.nx_slot = r_a;
                o_req.nx_data = r_b;
                o_req.pv_we   = 1'b1;
                o_req.pv_slot = r_b;
                o_req.pv_data = r_a;
                o_req.dd_we   = 1'b1;
                o_req.dd_idx  = dlle_pkg::IDX_W'(r_ref - dlle_pkg::REF_W'(1));
                o_req.dd_data = 1'b1;
                fin           = out_free;
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            S_QDONE: begin
                fin_sref = r_sref;
                fin_sval = i_rsp.val_q;
                fin      = out_free;
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_ref <= i_node_ref;
            r_val <= i_data_value;
        end
        r_a    <= n_a;
        r_b    <= n_b;
        r_sref <= n_sref;
        if (fin) begin
            r_status   <= fin_status;
            r_assigned <= fin_assigned;
            r_succ_ref <= fin_sref;
            r_succ_val <= fin_sval;
            r_at_end   <= fin_end;
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_assigned_ref    = r_assigned;
    assign o_successor_ref   = r_succ_ref;
    assign o_successor_value = r_succ_val;
    assign o_at_end          = r_at_end;

endmodule

// File: sv/dlle_checker.sv
// ----------------------------------------------------------------------------
// dlle_checker
// Port-level checks on the result channel of the linked list engine.
// ----------------------------------------------------------------------------
module dlle_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [dlle_pkg::STS_W-1:0]         o_status,
    input logic [dlle_pkg::REF_W-1:0]         o_assigned_ref,
    input logic [dlle_pkg::REF_W-1:0]         o_successor_ref,
    input logic signed [dlle_pkg::DATA_W-1:0] o_successor_value,
    input logic                               o_at_end
);

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_assigned_ref) && $stable(o_successor_ref)
            && $stable(o_successor_value) && $stable(o_at_end))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A failed command reports nothing besides its status.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != dlle_pkg::STS_OK |-> o_assigned_ref == '0
            && o_successor_ref == '0 && o_successor_value == '0 && !o_at_end)
        else $error("error result carries data");

    // A push or insert result and a query result never mix.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_assigned_ref != '0 || o_at_end) |->
            o_successor_ref == '0 && o_successor_value == '0)
        else $error("result fields of two commands mixed");

endmodule

bind doubly_linked_list_engine_top dlle_checker u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_assigned_ref    (o_assigned_ref),
    .o_successor_ref   (o_successor_ref),
    .o_successor_value (o_successor_value),
    .o_at_end          (o_at_end)
);

// File: tb/tb_doubly_linked_list_engine_top.sv
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_engine_top
// Self-checking bench for the doubly linked list engine. A scoreboard class
// keeps its own copy of the link, value and liveness stores, predicts the
// result of every accepted command and checks each returned result in order.
// Stimulus runs a directed pass over the edge cases, then random commands that
// grow the list, delete nodes and walk it by successor queries. It then fills
// the store and exercises the full-store responses, with random idling and
// stalls on both channels.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_engine_top;

    localparam logic [dlle_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [dlle_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS   = 800;
    localparam int FULL_ITEMS     = 150;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES    = 12;
    localparam int RUN_LIMIT      = 4000000;

    typedef struct {
        dlle_pkg::t_status           status;
        logic [dlle_pkg::REF_W-1:0]  assigned_ref;
        logic [dlle_pkg::REF_W-1:0]  successor_ref;
        logic [dlle_pkg::DATA_W-1:0] successor_value;
        logic                        at_end;
    } t_list_result;

    class list_scoreboard;
        logic [dlle_pkg::SLOT_W-1:0] fwd_link   [0:dlle_pkg::NODES+1];
        logic [dlle_pkg::SLOT_W-1:0] back_link  [0:dlle_pkg::NODES+1];
        logic [dlle_pkg::DATA_W-1:0] node_value [0:dlle_pkg::NODES-1];
        bit                          in_list    [0:dlle_pkg::NODES-1];
        logic [dlle_pkg::REF_W-1:0]  refs_issued;
        logic [dlle_pkg::REF_W-1:0]  walk_ref;
        int                          live_refs[$];
        int                          dead_refs[$];
        t_list_result                expected_q[$];
        int unsigned                 mismatches;

        function new();
            foreach (fwd_link[i]) begin
                fwd_link[i]  = '0;
                back_link[i] = '0;
            end
            foreach (in_list[i]) in_list[i] = 1'b0;
            fwd_link[dlle_pkg::HEAD_SLOT]  = dlle_pkg::TAIL_SLOT;
            back_link[dlle_pkg::TAIL_SLOT] = dlle_pkg::HEAD_SLOT;
            refs_issued = '0;
            walk_ref    = '0;
            mismatches  = 0;
        endfunction

        function bit is_live(logic [dlle_pkg::REF_W-1:0] r);
            return (r != 0) && (r <= refs_issued) && in_list[r-1];
        endfunction

        // Splices a new node between slots a and b, a preceding b.
        function logic [dlle_pkg::REF_W-1:0] link_node(logic [dlle_pkg::SLOT_W-1:0] a,
                                                       logic [dlle_pkg::SLOT_W-1:0] b,
                                                       logic [dlle_pkg::DATA_W-1:0] value);
            logic [dlle_pkg::REF_W-1:0]  r;
            logic [dlle_pkg::SLOT_W-1:0] s;
            r = refs_issued + 1'b1;
            s = r + 1'b1;
            node_value[r-1] = value;
            in_list[r-1]    = 1'b1;
            back_link[s]    = a;
            fwd_link[s]     = b;
            fwd_link[a]     = s;
            back_link[b]    = s;
            refs_issued     = r;
            live_refs       = {live_refs, int'(r)};
            return r;
        endfunction

        function void note_command(logic [dlle_pkg::CMD_W-1:0] cmd,
                                   logic [dlle_pkg::REF_W-1:0] r,
                                   logic [dlle_pkg::DATA_W-1:0] value);
            t_list_result                exp;
            logic [dlle_pkg::SLOT_W-1:0] slot;
            logic [dlle_pkg::SLOT_W-1:0] a;
            logic [dlle_pkg::SLOT_W-1:0] b;
            exp.status          = dlle_pkg::STS_OK;
            exp.assigned_ref    = '0;
            exp.successor_ref   = '0;
            exp.successor_value = '0;
            exp.at_end          = 1'b0;
            slot = r + 1'b1;
            case (cmd)
                dlle_pkg::CMD_PUSH_FRONT, dlle_pkg::CMD_PUSH_BACK: begin
                    if (refs_issued >= dlle_pkg::NODES)
                        exp.status = dlle_pkg::STS_FULL;
                    else if (cmd == dlle_pkg::CMD_PUSH_FRONT)
                        exp.assigned_ref = link_node(dlle_pkg::HEAD_SLOT,
                                                     fwd_link[dlle_pkg::HEAD_SLOT], value);
                    else
                        exp.assigned_ref = link_node(back_link[dlle_pkg::TAIL_SLOT],
                                                     dlle_pkg::TAIL_SLOT, value);
                end
                dlle_pkg::CMD_INSERT_BEFORE, dlle_pkg::CMD_INSERT_AFTER: begin
                    // The reference check wins over the full check.
                    if (!is_live(r))
                        exp.status = dlle_pkg::STS_BAD;
                    else if (refs_issued >= dlle_pkg::NODES)
                        exp.status = dlle_pkg::STS_FULL;
                    else if (cmd == dlle_pkg::CMD_INSERT_BEFORE)
                        exp.assigned_ref = link_node(back_link[slot], slot, value);
                    else
                        exp.assigned_ref = link_node(slot, fwd_link[slot], value);
                end
                dlle_pkg::CMD_DELETE: begin
                    if (!is_live(r)) begin
                        exp.status = dlle_pkg::STS_BAD;
                    end else begin
                        a = back_link[slot];
                        b = fwd_link[slot];
                        fwd_link[a]  = b;
                        back_link[b] = a;
                        in_list[r-1] = 1'b0;
                        foreach (live_refs[i]) begin
                            if (live_refs[i] == r) begin
                                live_refs.delete(i);
                                break;
                            end
                        end
                        dead_refs = {dead_refs, int'(r)};
                    end
                end
                dlle_pkg::CMD_QUERY_NEXT: begin
                    if (r != 0 && !is_live(r)) begin
                        exp.status = dlle_pkg::STS_BAD;
                    end else begin
                        a = fwd_link[(r == 0) ? dlle_pkg::HEAD_SLOT : slot];
                        if (a == dlle_pkg::TAIL_SLOT) begin
                            exp.at_end = 1'b1;
                            walk_ref   = '0;
                        end else begin
                            exp.successor_ref   = a - 1'b1;
                            exp.successor_value = node_value[a-2];
                            walk_ref            = a - 1'b1;
                        end
                    end
                end
                default: exp.status = dlle_pkg::STS_BAD;
            endcase
            expected_q = {expected_q, exp};
        endfunction

        function void field_diff(string name, logic [dlle_pkg::DATA_W-1:0] want,
                                 logic [dlle_pkg::DATA_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [dlle_pkg::STS_W-1:0] sts,
                                   logic [dlle_pkg::REF_W-1:0] assigned,
                                   logic [dlle_pkg::REF_W-1:0] succ_ref,
                                   logic [dlle_pkg::DATA_W-1:0] succ_val,
                                   logic fin);
            t_list_result exp;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no command waiting, expected none, actual status %0d",
                         $time, sts);
                mismatches++;
            end else begin
                exp = expected_q.pop_front();
                field_diff("status", exp.status, sts);
                field_diff("assigned_ref", exp.assigned_ref, assigned);
                field_diff("successor_ref", exp.successor_ref, succ_ref);
                field_diff("successor_value", exp.successor_value, succ_val);
                field_diff("at_end", exp.at_end, fin);
            end
        endfunction
    endclass

    logic                               i_clk        = 1'b0;
    logic                               i_rst_n      = 1'b0;
    logic                               i_in_valid   = 1'b0;
    logic [dlle_pkg::CMD_W-1:0]         i_command    = '0;
    logic [dlle_pkg::REF_W-1:0]         i_node_ref   = '0;
    logic signed [dlle_pkg::DATA_W-1:0] i_data_value = '0;
    logic                               i_out_ready  = 1'b0;
    logic                               o_in_ready;
    logic                               o_out_valid;
    logic [dlle_pkg::STS_W-1:0]         o_status;
    logic [dlle_pkg::REF_W-1:0]         o_assigned_ref;
    logic [dlle_pkg::REF_W-1:0]         o_successor_ref;
    logic signed [dlle_pkg::DATA_W-1:0] o_successor_value;
    logic                               o_at_end;

    // Both are written by the sender only, through nonblocking assignments.
    logic                               calm         = 1'b0;
    int unsigned                        hold_tickets = 0;

    list_scoreboard sb = new();

    doubly_linked_list_engine_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_node_ref        (i_node_ref),
        .i_data_value      (i_data_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_assigned_ref    (o_assigned_ref),
        .o_successor_ref   (o_successor_ref),
        .o_successor_value (o_successor_value),
        .o_at_end          (o_at_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, a calm window, and long hold-offs on request.
    initial begin
        int unsigned holds_served;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_tickets != holds_served) begin
                holds_served++;
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (calm) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= 36);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_assigned_ref, o_successor_ref, o_successor_value,
                            o_at_end);
    end

    task automatic send_command(input logic [dlle_pkg::CMD_W-1:0] cmd,
                                input logic [dlle_pkg::REF_W-1:0] r,
                                input logic [dlle_pkg::DATA_W-1:0] value);
        while (!calm && $urandom_range(0, 99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_node_ref   <= r;
        i_data_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_command(cmd, r, value);
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [dlle_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly live nodes, with deleted, out-of-range and zero references mixed in.
    function automatic logic [dlle_pkg::REF_W-1:0] pick_ref(bit for_query);
        int roll;
        roll = $urandom_range(0, 99);
        if (for_query && roll < 40)
            return sb.walk_ref;
        if (roll < 80 && sb.live_refs.size() != 0)
            return dlle_pkg::REF_W'(sb.live_refs[$urandom_range(0, sb.live_refs.size() - 1)]);
        if (roll < 88 && sb.dead_refs.size() != 0)
            return dlle_pkg::REF_W'(sb.dead_refs[$urandom_range(0, sb.dead_refs.size() - 1)]);
        if (roll < 95)
            return dlle_pkg::REF_W'($urandom_range(sb.refs_issued + 1, 2047));
        return '0;
    endfunction

    task automatic send_random_command(input int grow_pct);
        int                         roll;
        logic [dlle_pkg::CMD_W-1:0] cmd;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            send_command(dlle_pkg::CMD_W'($urandom_range(0, 7)), dlle_pkg::REF_W'($urandom),
                         $urandom);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < grow_pct)
                cmd = dlle_pkg::CMD_W'($urandom_range(dlle_pkg::CMD_PUSH_FRONT,
                                                      dlle_pkg::CMD_INSERT_AFTER));
            else if (roll < grow_pct + (100 - grow_pct) / 2)
                cmd = dlle_pkg::CMD_DELETE;
            else
                cmd = dlle_pkg::CMD_QUERY_NEXT;
            send_command(cmd, pick_ref(cmd == dlle_pkg::CMD_QUERY_NEXT), pick_value());
        end
    endtask

    initial begin
        logic [dlle_pkg::REF_W-1:0] r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Empty list, then a small list built and unlinked by hand.
        send_command(dlle_pkg::CMD_QUERY_NEXT, 11'd0, '0);
        send_command(dlle_pkg::CMD_DELETE, 11'd0, '0);
        send_command(dlle_pkg::CMD_INSERT_AFTER, 11'd1, 32'h1234_5678);
        send_command(dlle_pkg::CMD_PUSH_FRONT, 11'd0, 32'h7FFF_FFFF);
        send_command(dlle_pkg::CMD_PUSH_BACK, 11'd0, 32'h8000_0000);
        send_command(dlle_pkg::CMD_INSERT_BEFORE, 11'd2, 32'h0000_0000);
        send_command(dlle_pkg::CMD_INSERT_AFTER, 11'd1, 32'hFFFF_FFFF);
        send_command(dlle_pkg::CMD_QUERY_NEXT, 11'd0, '0);
        send_command(dlle_pkg::CMD_QUERY_NEXT, 11'd1, '0);
        send_command(dlle_pkg::CMD_QUERY_NEXT, 11'd4, '0);
        send_command(dlle_pkg::CMD_QUERY_NEXT, 11'd3, '0);
        send_command(dlle_pkg::CMD_QUERY_NEXT, 11'd2, '0);
        send_command(dlle_pkg::CMD_DELETE, 11'd3, '0);
        send_command(dlle_pkg::CMD_DELETE, 11'd3, '0);
        send_command(dlle_pkg::CMD_QUERY_NEXT, 11'd3, '0);
        send_command(dlle_pkg::CMD_INSERT_BEFORE, 11'd3, 32'h5A5A_A5A5);
        send_command(dlle_pkg::CMD_INSERT_AFTER, 11'd2, 32'hA5A5_5A5A);
        send_command(dlle_pkg::CMD_DELETE, 11'd6, '0);
        send_command(dlle_pkg::CMD_QUERY_NEXT, 11'd2047, '0);
        send_command(dlle_pkg::CMD_INSERT_BEFORE, 11'd1024, 32'h1);
        send_command(CMD_SPARE_LO, 11'd1, 32'h2);
        send_command(CMD_SPARE_HI, 11'd0, 32'h3);
        send_command(dlle_pkg::CMD_DELETE, 11'd1, '0);
        send_command(dlle_pkg::CMD_QUERY_NEXT, 11'd0, '0);
        send_command(dlle_pkg::CMD_INSERT_BEFORE, 11'd0, 32'h4);
        wait_results_done();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200) hold_tickets <= hold_tickets + 1;
            if (n == 350) calm <= 1'b1;
            if (n == 550) calm <= 1'b0;
            if (n == 650) wait_results_done();
            send_random_command((n < 650) ? 70 : 40);
        end

        // Use up every remaining reference so that the full-store path is reached.
        while (sb.refs_issued < dlle_pkg::NODES) begin
            if (sb.live_refs.size() != 0 && $urandom_range(0, 1))
                send_command(dlle_pkg::CMD_W'($urandom_range(dlle_pkg::CMD_INSERT_BEFORE,
                                                             dlle_pkg::CMD_INSERT_AFTER)),
                             dlle_pkg::REF_W'(sb.live_refs[$urandom_range(0,
                                                           sb.live_refs.size() - 1)]),
                             pick_value());
            else
                send_command(dlle_pkg::CMD_W'($urandom_range(dlle_pkg::CMD_PUSH_FRONT,
                                                             dlle_pkg::CMD_PUSH_BACK)),
                             '0, pick_value());
        end

        r = (sb.live_refs.size() != 0) ? dlle_pkg::REF_W'(sb.live_refs[0]) : 11'd1;
        send_command(dlle_pkg::CMD_PUSH_FRONT, 11'd0, 32'h1111_1111);
        send_command(dlle_pkg::CMD_PUSH_BACK, 11'd0, 32'h2222_2222);
        send_command(dlle_pkg::CMD_INSERT_AFTER, r, 32'h3333_3333);
        send_command(dlle_pkg::CMD_INSERT_BEFORE,
                     (sb.dead_refs.size() != 0) ? dlle_pkg::REF_W'(sb.dead_refs[0]) : 11'd0,
                     32'h4444_4444);
        send_command(dlle_pkg::CMD_INSERT_AFTER, 11'd0, 32'h5555_5555);
        send_command(dlle_pkg::CMD_INSERT_BEFORE, 11'd2047, 32'h6666_6666);
        send_command(dlle_pkg::CMD_DELETE, r, '0);
        send_command(dlle_pkg::CMD_PUSH_BACK, 11'd0, 32'h7777_7777);
        send_command(dlle_pkg::CMD_QUERY_NEXT, 11'd0, '0);

        for (int n = 0; n < FULL_ITEMS; n++)
            send_random_command(50);

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/dlle_pkg.sv
sv/dlle_link_store.sv
sv/dlle_seq.sv
sv/doubly_linked_list_engine_top.sv
sv/dlle_checker.sv
tb/tb_doubly_linked_list_engine_top.sv
